// ===== sv/word_split_lexer_defines.svh =====
// assertion macros for the word splitting lexer
`ifndef WORD_SPLIT_LEXER_DEFINES_SVH
`define WORD_SPLIT_LEXER_DEFINES_SVH

`ifndef SYNTH
`define WSL_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("wsl check failed");
`define WSL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("wsl check failed");
`else
`define WSL_ASSERT_RST(lbl, clk, rst_n, prop)
`define WSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/wsl_pkg.sv =====
package wsl_pkg;

  localparam int MAX_WORD_DEF = 32;
  localparam int POS_BITS_DEF = 16;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ASSIGN = 8'h3d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_O      = 8'h6f;

  typedef enum logic [3:0] {
    KIND_DEF     = 4'd0,
    KIND_DO      = 4'd1,
    KIND_END     = 4'd2,
    KIND_ASSIGN  = 4'd3,
    KIND_PLUS    = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_COMMA   = 4'd7,
    KIND_INT     = 4'd8,
    KIND_IDENT   = 4'd9,
    KIND_ILLEGAL = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  is_int;
    logic  is_ident;
  } cls_t;

  function automatic kind_t special_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_ASSIGN: k = KIND_ASSIGN;
      CH_PLUS:   k = KIND_PLUS;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return special_kind(c) != KIND_ILLEGAL;
  endfunction

endpackage

// ===== sv/wsl_ram.sv =====
module wsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/wsl_classify.sv =====
module wsl_classify #(
  parameter int MAX_WORD = wsl_pkg::MAX_WORD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  input  logic                            push,
  input  logic [7:0]                      ch,
  output wsl_pkg::cls_t                   cls,
  output logic [$clog2(MAX_WORD+1)-1:0]   cnt
);
  import wsl_pkg::*;

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam logic [31:0] VAL_SAT = 32'h8000_0001;

  typedef enum logic [4:0] {
    P_WS   = 5'b00001,
    P_SIGN = 5'b00010,
    P_DIG  = 5'b00100,
    P_DONE = 5'b01000,
    P_FAIL = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [LW-1:0] cnt_r;
  logic [7:0]  b0_r, b1_r, b2_r;
  logic [31:0] val_r, val_nxt;
  logic        neg_r, neg_nxt;
  logic        letter_r, bad_r;
  logic        is_dig, is_let, is_ws;
  logic [3:0]  dig;
  logic [35:0] acc;
  logic        int_ok, kw_def, kw_do, kw_end;

  always_comb begin
    is_dig = ch inside {[8'h30:8'h39]};
    is_let = ch inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h5f};
    is_ws  = ch inside {[8'h09:8'h0d], CH_SPACE};
    dig    = ch[3:0];
    acc    = {val_r, 3'b000} + {3'b000, val_r, 1'b0} + {32'd0, dig};
  end

  always_comb begin
    phase_nxt = phase_r;
    val_nxt   = val_r;
    neg_nxt   = neg_r;
    case (phase_r)
      P_WS: begin
        if (is_ws) phase_nxt = P_WS;
        else if (ch == CH_PLUS || ch == CH_MINUS) begin
          neg_nxt   = ch == CH_MINUS;
          phase_nxt = P_SIGN;
        end else if (is_dig) begin
          val_nxt   = {28'd0, dig};
          phase_nxt = P_DIG;
        end else phase_nxt = P_FAIL;
      end
      P_SIGN: begin
        if (is_dig) begin
          val_nxt   = {28'd0, dig};
          phase_nxt = P_DIG;
        end else phase_nxt = P_FAIL;
      end
      P_DIG: begin
        if (is_dig) val_nxt = (acc > {4'd0, VAL_SAT}) ? VAL_SAT : acc[31:0];
        else phase_nxt = P_DONE;
      end
      P_DONE:  phase_nxt = P_DONE;
      P_FAIL:  phase_nxt = P_FAIL;
      default: phase_nxt = P_FAIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      phase_r  <= P_WS;
      cnt_r    <= '0;
      val_r    <= '0;
      neg_r    <= 1'b0;
      letter_r <= 1'b0;
      bad_r    <= 1'b0;
    end else if (push) begin
      phase_r  <= phase_nxt;
      val_r    <= val_nxt;
      neg_r    <= neg_nxt;
      cnt_r    <= cnt_r + LW'(1);
      letter_r <= letter_r | is_let;
      bad_r    <= bad_r | is_dig | is_special(ch);
    end
  end

  // first three bytes kept for keyword and single special tests
  always_ff @(posedge clk) begin
    if (push && cnt_r == LW'(0)) b0_r <= ch;
    if (push && cnt_r == LW'(1)) b1_r <= ch;
    if (push && cnt_r == LW'(2)) b2_r <= ch;
  end

  always_comb begin
    int_ok = (phase_r == P_DIG || phase_r == P_DONE) &&
             (neg_r ? (val_r <= 32'h8000_0000) : (val_r <= 32'h7fff_ffff));
    kw_def = cnt_r == LW'(3) && b0_r == CH_D && b1_r == CH_E && b2_r == CH_F;
    kw_do  = cnt_r == LW'(2) && b0_r == CH_D && b1_r == CH_O;
    kw_end = cnt_r == LW'(3) && b0_r == CH_E && b1_r == CH_N && b2_r == CH_D;
    cls.is_int   = int_ok;
    cls.is_ident = letter_r && !bad_r;
    if (kw_def) cls.kind = KIND_DEF;
    else if (kw_do) cls.kind = KIND_DO;
    else if (kw_end) cls.kind = KIND_END;
    else if (cnt_r == LW'(1) && is_special(b0_r)) cls.kind = special_kind(b0_r);
    else if (int_ok) cls.kind = KIND_INT;
    else if (letter_r && !bad_r) cls.kind = KIND_IDENT;
    else cls.kind = KIND_ILLEGAL;
  end

  assign cnt = cnt_r;
endmodule

// ===== sv/word_split_lexer.sv =====
// word splitting lexer
// input channel: one expression byte per beat (in_char_code) with
// in_end_of_expression marking the final byte. output channel: one token per
// beat (kind, start offset, length, overflow flag, last_in_run on the final
// token caused by one input byte).
// a byte that does not end a word is taken and, while the word buffer has
// room, written to the word buffer ram. a space or the final byte ends the
// word: in_stall stays high while the word is finished. a word classified
// whole, an empty word or an overlong word gives its single token from S_FIN
// into the output register. a word that is split walks the buffer ram byte by
// byte (S_RD reads, then S_BYTE classifies), plus an S_SPEC step for every
// special byte after a piece and an S_TAIL step for the trailing piece.
// the walk is set by the single read port of the buffer ram.
// while out_stall is high a held token stays put and the walk waits to emit.
// reset (rst_n low, synchronous) empties the word, zeroes the byte offset and
// drops any pending token; no clearing pass is needed.
module word_split_lexer #(
  parameter int MAX_WORD = wsl_pkg::MAX_WORD_DEF,
  parameter int POSITION_BITS = wsl_pkg::POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_expression,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_token_kind,
  output logic [15:0] out_token_start,
  output logic [5:0] out_token_length,
  output logic       out_word_overflow,
  output logic       out_last_in_run
);
  import wsl_pkg::*;

  `include "word_split_lexer_defines.svh"

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);
  localparam int PB = POSITION_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FIN  = 6'b000010,
    S_RD   = 6'b000100,
    S_BYTE = 6'b001000,
    S_SPEC = 6'b010000,
    S_TAIL = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] fill_r, len_r, j_r, poff_r;
  logic          tl_r, ovf_r;
  logic [PB-1:0] pos_r, begin_r, base_r;

  logic in_acc, is_sp, room, w_push, w_clr, p_push, p_clr, ram_re;
  logic [7:0] rdata;
  cls_t w_cls, p_cls;
  logic [LW-1:0] w_cnt, p_cnt;
  logic j_last, c_spec, free;

  // token being loaded into the output register
  logic          emit;
  kind_t         e_kind;
  logic [PB-1:0] e_start;
  logic [LW-1:0] e_len;
  logic          e_ovf, e_last;

  logic          ov_r;
  kind_t         ok_r;
  logic [PB-1:0] os_r;
  logic [LW-1:0] ol_r;
  logic          oo_r, olast_r;

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign is_sp    = in_char_code == CH_SPACE;
  assign room     = fill_r < LW'(MAX_WORD);
  assign w_push   = in_acc && !is_sp && room;
  assign free     = !ov_r || !out_stall;
  assign j_last   = j_r == len_r - LW'(1);
  assign c_spec   = is_special(rdata);

  wsl_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_buf (
    .clk   (clk),
    .we    (w_push),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_char_code),
    .re    (ram_re),
    .raddr (j_r[AW-1:0]),
    .rdata (rdata)
  );

  wsl_classify #(.MAX_WORD(MAX_WORD)) u_word (
    .clk(clk), .rst_n(rst_n), .clr(w_clr), .push(w_push), .ch(in_char_code),
    .cls(w_cls), .cnt(w_cnt)
  );

  wsl_classify #(.MAX_WORD(MAX_WORD)) u_piece (
    .clk(clk), .rst_n(rst_n), .clr(p_clr), .push(p_push), .ch(rdata),
    .cls(p_cls), .cnt(p_cnt)
  );

  always_comb begin
    state_nxt = state_r;
    emit = 1'b0; e_kind = KIND_ILLEGAL; e_start = base_r; e_len = len_r;
    e_ovf = 1'b0; e_last = 1'b0;
    w_clr = 1'b0; p_clr = 1'b0; p_push = 1'b0; ram_re = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (is_sp || in_end_of_expression)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (free) begin
          if (ovf_r) begin
            emit = 1'b1; e_len = LW'(MAX_WORD); e_ovf = 1'b1; e_last = 1'b1;
            w_clr = 1'b1; state_nxt = S_IDLE;
          end else if (len_r <= LW'(1) || w_cls.is_ident || w_cls.is_int) begin
            emit = 1'b1; e_kind = w_cls.kind; e_last = 1'b1;
            w_clr = 1'b1; state_nxt = S_IDLE;
          end else begin
            p_clr = 1'b1; state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re = 1'b1; state_nxt = S_BYTE;
      end
      S_BYTE: begin
        if (c_spec) begin
          if (free) begin
            emit = 1'b1;
            if (p_cnt != LW'(0)) begin
              // pending piece goes out first, the special follows
              e_kind = p_cls.kind; e_start = base_r + PB'(poff_r); e_len = p_cnt;
              p_clr = 1'b1; state_nxt = S_SPEC;
            end else begin
              e_kind = special_kind(rdata); e_start = base_r + PB'(j_r);
              e_len = LW'(1); e_last = j_last;
              if (j_last) begin
                w_clr = 1'b1; state_nxt = S_IDLE;
              end else state_nxt = S_RD;
            end
          end
        end else begin
          p_push = 1'b1;
          state_nxt = j_last ? S_TAIL : S_RD;
        end
      end
      S_SPEC: begin
        if (free) begin
          emit = 1'b1; e_kind = special_kind(rdata); e_start = base_r + PB'(j_r);
          e_len = LW'(1); e_last = j_last;
          if (j_last) begin
            w_clr = 1'b1; state_nxt = S_IDLE;
          end else state_nxt = S_RD;
        end
      end
      S_TAIL: begin
        if (free) begin
          emit = 1'b1; e_kind = p_cls.kind; e_start = base_r + PB'(poff_r);
          e_len = p_cnt; e_last = 1'b1;
          w_clr = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      tl_r    <= 1'b0;
      pos_r   <= '0;
      begin_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_end_of_expression) begin
          pos_r <= '0; begin_r <= '0; fill_r <= '0; tl_r <= 1'b0;
        end else begin
          pos_r <= pos_r + PB'(1);
          if (is_sp) begin
            begin_r <= pos_r + PB'(1); fill_r <= '0; tl_r <= 1'b0;
          end else if (room) fill_r <= fill_r + LW'(1);
          else tl_r <= 1'b1;
        end
      end
      if (emit) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  // word snapshot for the finish walk and the walk counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= begin_r;
      len_r  <= (!is_sp && room) ? fill_r + LW'(1) : fill_r;
      ovf_r  <= tl_r || (!is_sp && !room);
    end
    if (state_r == S_FIN) begin
      j_r <= '0; poff_r <= '0;
    end
    if (emit && (state_r == S_SPEC || (state_r == S_BYTE && p_cnt == LW'(0))))
      poff_r <= j_r + LW'(1);
    if (state_nxt == S_RD && (state_r == S_BYTE || state_r == S_SPEC))
      j_r <= j_r + LW'(1);
    if (emit) begin
      ok_r <= e_kind; os_r <= e_start; ol_r <= e_len; oo_r <= e_ovf;
      olast_r <= e_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_token_kind    = 4'(ok_r);
  assign out_token_start   = 16'(os_r);
  assign out_token_length  = (7'(ol_r) > 7'd63) ? 6'd63 : 6'(ol_r);
  assign out_word_overflow = oo_r;
  assign out_last_in_run   = olast_r;

  `WSL_ASSERT_RST(a_fill_bound, clk, rst_n, fill_r <= LW'(MAX_WORD))
  `WSL_ASSERT_RST(a_ovf_illegal, clk, rst_n, (ov_r && oo_r) |-> ok_r == KIND_ILLEGAL)
  `WSL_ASSERT_RST(a_walk_in_word, clk, rst_n, (state_r == S_BYTE || state_r == S_SPEC) |-> j_r < len_r)
  `WSL_ASSERT_RST(a_word_count, clk, rst_n, (state_r == S_FIN && !ovf_r) |-> w_cnt == len_r)
endmodule
